// ===== rtl/core/ttag_pkg.sv =====
// ----------------------------------------------------------------------------
// ttag_pkg: shared types and constants of the transpose address generator
// Widths, register indexes, the configuration and queue-entry structs and
// helpers that clamp raw register values to their working range.
// ----------------------------------------------------------------------------
package ttag_pkg;

  // Sizing of the datapath.
  localparam int MAX_RANK      = 4;
  localparam int NUM_DIMS      = 4;
  localparam int ADDR_BITS     = 24;
  localparam int DIM_BITS      = 12;
  localparam int SIZE_BITS     = DIM_BITS + 1;
  localparam int PROD_BITS     = ADDR_BITS + 1;
  localparam int ELEM_BITS     = 32;
  localparam int RANK_BITS     = 3;
  localparam int DIM_IDX_BITS  = 2;
  localparam int PERM_BITS     = NUM_DIMS * DIM_IDX_BITS;
  localparam int CFG_SIZE_BITS = 13;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RANK  = 3'd0,
    REG_SIZE0 = 3'd1,
    REG_SIZE1 = 3'd2,
    REG_SIZE2 = 3'd3,
    REG_SIZE3 = 3'd4,
    REG_PERM  = 3'd5
  } ttag_reg_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } ttag_back_state_t;

  // Working configuration, already clamped to legal ranges.
  typedef struct packed {
    logic [RANK_BITS-1:0]                 rank;
    logic [NUM_DIMS-1:0][SIZE_BITS-1:0]   size;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0]    lim;
    logic [PERM_BITS-1:0]                 perm;
  } ttag_cfg_t;

  // One classified item waiting for its address.
  typedef struct packed {
    logic [ELEM_BITS-1:0]                 element;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0]    pos;
    logic                                 last;
  } ttag_entry_t;

  // A rank of zero acts as one, a rank above the maximum as the maximum.
  function automatic logic [RANK_BITS-1:0] eff_rank(input logic [RANK_BITS-1:0] raw);
    logic [RANK_BITS-1:0] r;
    r = raw;
    if (r == '0) r = RANK_BITS'(1);
    if (int'(r) > MAX_RANK) r = RANK_BITS'(MAX_RANK);
    return r;
  endfunction

  // A size of zero acts as one, a size above 2^DIM_BITS as 2^DIM_BITS.
  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [CFG_SIZE_BITS-1:0] raw);
    logic [31:0] s;
    s = 32'(raw);
    if (s == 32'd0) s = 32'd1;
    if (s > (32'd1 << DIM_BITS)) s = 32'd1 << DIM_BITS;
    return SIZE_BITS'(s);
  endfunction

endpackage

// ===== rtl/core/ttag_front.sv =====
// ----------------------------------------------------------------------------
// ttag_front: input acceptance and odometer
// Accepts one item per cycle while the queue has room, snapshots the position
// counters, flags the final element and advances the odometer.
// ----------------------------------------------------------------------------
module ttag_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ttag_pkg::ttag_cfg_t               cfg,
  input  logic                              in_valid,
  input  logic [ttag_pkg::ELEM_BITS-1:0]    in_element_in,
  output logic                              in_stall,
  input  logic                              q_full,
  output logic                              q_push,
  output ttag_pkg::ttag_entry_t             q_push_data
);
  import ttag_pkg::*;

  logic [NUM_DIMS-1:0][DIM_BITS-1:0] cnt_r;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] cnt_nxt;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] snap;
  logic                              last;

  // The item is taken whenever the queue can hold it.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Odometer: innermost dimension first; dimensions beyond the rank read as zero.
  always_comb begin
    logic carry;
    logic at_lim;
    carry   = 1'b1;
    at_lim  = 1'b0;
    cnt_nxt = cnt_r;
    snap    = '0;
    for (int j = NUM_DIMS - 1; j >= 0; j--) begin
      if (j < int'(cfg.rank)) begin
        snap[j] = cnt_r[j];
        at_lim  = (cnt_r[j] >= cfg.lim[j]);
        if (carry) begin
          cnt_nxt[j] = at_lim ? '0 : DIM_BITS'(cnt_r[j] + 1'b1);
        end
        carry = carry && at_lim;
      end else begin
        cnt_nxt[j] = '0;
      end
    end
    last = carry;
  end

  assign q_push_data.element = in_element_in;
  assign q_push_data.pos     = snap;
  assign q_push_data.last    = last;

  // Counters move only when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/ttag_queue.sv =====
// ----------------------------------------------------------------------------
// ttag_queue: short item queue between front and back
// A small register FIFO that lets the front keep accepting while the back end
// works on an earlier item.
// ----------------------------------------------------------------------------
module ttag_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ttag_pkg::ttag_entry_t   push_data,
  output logic                    full,
  input  logic                    pop,
  output ttag_pkg::ttag_entry_t   pop_data,
  output logic                    empty
);
  import ttag_pkg::*;

  ttag_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;

  assign full     = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill-count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : QPTR_BITS'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : QPTR_BITS'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= QCNT_BITS'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= QCNT_BITS'(count_r - 1'b1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ttag_back.sv =====
// ----------------------------------------------------------------------------
// ttag_back: address computation and result register
// Takes one item from the queue and builds its output address in row-major
// order with one multiply-add per output dimension, while a second multiplier
// checks the tensor size against the address space.
// ----------------------------------------------------------------------------
module ttag_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ttag_pkg::ttag_cfg_t               cfg,
  input  logic                              q_empty,
  input  ttag_pkg::ttag_entry_t             q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ttag_pkg::ADDR_BITS-1:0]    out_address,
  output logic [ttag_pkg::ELEM_BITS-1:0]    out_element_out,
  output logic                              out_last_element,
  output logic                              out_size_error
);
  import ttag_pkg::*;

  ttag_back_state_t               state_r;
  ttag_back_state_t               state_nxt;
  ttag_entry_t                    ent_r;
  logic [ADDR_BITS-1:0]           acc_r;
  logic [ADDR_BITS-1:0]           acc_nxt;
  logic [PROD_BITS-1:0]           prod_r;
  logic                           ovf_r;
  logic [DIM_IDX_BITS-1:0]        iter_r;
  logic                           out_valid_r;
  logic [ADDR_BITS-1:0]           out_addr_r;
  logic [ELEM_BITS-1:0]           out_elem_r;
  logic                           out_last_r;
  logic                           out_err_r;

  logic                           iter_last;
  logic                           out_free;
  logic                           do_step;
  logic                           load_out;
  logic [DIM_IDX_BITS-1:0]        d;
  logic                           use_d;
  logic [SIZE_BITS-1:0]           sz;
  logic [DIM_BITS-1:0]            pos;
  logic [ADDR_BITS+SIZE_BITS-1:0] mul_a;
  logic [PROD_BITS+SIZE_BITS-1:0] mul_p;
  logic                           too_big;

  assign iter_last = (RANK_BITS'(iter_r) + RANK_BITS'(1)) == cfg.rank;
  assign out_free  = !out_valid_r || !out_stall;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_CALC;
      end
      BK_CALC: begin
        if (iter_last) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    do_step  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = !q_empty;
      BK_CALC: do_step  = 1'b1;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // One Horner step: output position iter_r holds input dimension d.
  always_comb begin
    d       = cfg.perm[DIM_IDX_BITS*iter_r +: DIM_IDX_BITS];
    use_d   = (RANK_BITS'(d) < cfg.rank);
    sz      = use_d ? cfg.size[d] : SIZE_BITS'(1);
    pos     = use_d ? ent_r.pos[d] : '0;
    mul_a   = acc_r * sz;
    acc_nxt = ADDR_BITS'(mul_a) + ADDR_BITS'(pos);
    mul_p   = prod_r * cfg.size[iter_r];
    too_big = (mul_p > (PROD_BITS + SIZE_BITS)'(1) << ADDR_BITS);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_data;
      acc_r  <= '0;
      prod_r <= PROD_BITS'(1);
      ovf_r  <= 1'b0;
      iter_r <= '0;
    end else if (do_step) begin
      acc_r  <= acc_nxt;
      iter_r <= DIM_IDX_BITS'(iter_r + 1'b1);
      // The product saturates at the address space once it has passed it.
      if (too_big) begin
        ovf_r  <= 1'b1;
        prod_r <= PROD_BITS'(1) << ADDR_BITS;
      end else begin
        prod_r <= PROD_BITS'(mul_p);
      end
    end
    if (load_out) begin
      out_addr_r <= acc_r;
      out_elem_r <= ent_r.element;
      out_last_r <= ent_r.last;
      out_err_r  <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_address      = out_addr_r;
  assign out_element_out  = out_elem_r;
  assign out_last_element = out_last_r;
  assign out_size_error   = out_err_r;

endmodule

// ===== rtl/core/tensor_transpose_address_generator.sv =====
// The back end works on one item at a time: it takes an item from the queue only
// once the previous result has been loaded, and its single multiply-add unit
// takes one output dimension per cycle.
// The front accepts up to two items ahead of the back end through its queue.
// Reset (rst_n low, synchronous) clears the counters, empties the queue and
// result register, and loads rank 4, sizes 1 and the identity permutation.
// ----------------------------------------------------------------------------
// tensor_transpose_address_generator: top level
// Holds the configuration registers and joins the front end, the item queue
// and the back end that computes permuted output addresses.
// ----------------------------------------------------------------------------
module tensor_transpose_address_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ttag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ttag_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ttag_pkg::ELEM_BITS-1:0]       in_element_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ttag_pkg::ADDR_BITS-1:0]       out_address,
  output logic [ttag_pkg::ELEM_BITS-1:0]       out_element_out,
  output logic                                 out_last_element,
  output logic                                 out_size_error
);
  import ttag_pkg::*;

  logic [RANK_BITS-1:0]                    rank_r;
  logic [NUM_DIMS-1:0][CFG_SIZE_BITS-1:0]  size_r;
  logic [PERM_BITS-1:0]                    perm_r;
  ttag_cfg_t                               cfg;
  logic                                    q_push;
  ttag_entry_t                             q_push_data;
  logic                                    q_full;
  logic                                    q_pop;
  ttag_entry_t                             q_data;
  logic                                    q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_BITS'(4);
      size_r <= {NUM_DIMS{CFG_SIZE_BITS'(1)}};
      perm_r <= PERM_BITS'(228);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANK:  rank_r    <= cfg_data[RANK_BITS-1:0];
        REG_SIZE0: size_r[0] <= cfg_data[CFG_SIZE_BITS-1:0];
        REG_SIZE1: size_r[1] <= cfg_data[CFG_SIZE_BITS-1:0];
        REG_SIZE2: size_r[2] <= cfg_data[CFG_SIZE_BITS-1:0];
        REG_SIZE3: size_r[3] <= cfg_data[CFG_SIZE_BITS-1:0];
        REG_PERM:  perm_r    <= cfg_data[PERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp raw register values into their working ranges.
  always_comb begin
    cfg.rank = eff_rank(rank_r);
    cfg.perm = perm_r;
    for (int j = 0; j < NUM_DIMS; j++) begin
      cfg.size[j] = eff_size(size_r[j]);
      cfg.lim[j]  = DIM_BITS'(cfg.size[j] - 1'b1);
    end
  end

  ttag_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_element_in (in_element_in),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  ttag_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  ttag_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address      (out_address),
    .out_element_out  (out_element_out),
    .out_last_element (out_last_element),
    .out_size_error   (out_size_error)
  );

endmodule

// ===== rtl/core/ttag_checker.sv =====
// ----------------------------------------------------------------------------
// ttag_checker: port-level checks of the transpose address generator
// Tracks items in flight from the ports and checks the result channel against
// that count, and checks that a stalled result holds its value.
// ----------------------------------------------------------------------------
module ttag_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [ttag_pkg::ADDR_BITS-1:0]       out_address,
  input  logic [ttag_pkg::ELEM_BITS-1:0]       out_element_out,
  input  logic                                 out_last_element,
  input  logic                                 out_size_error
);
  import ttag_pkg::*;

  localparam int CAPACITY = QUEUE_DEPTH + 2;
  localparam int PEND_BITS = $clog2(CAPACITY + 2);

  logic                 in_take;
  logic                 out_take;
  logic [PEND_BITS-1:0] pend_r;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_take && !out_take) begin
      pend_r <= PEND_BITS'(pend_r + 1'b1);
    end else if (out_take && !in_take) begin
      pend_r <= PEND_BITS'(pend_r - 1'b1);
    end
  end

  // No result appears without an item behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result shown with no item in flight");

  // The block never holds more items than its storage allows.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pend_r) <= CAPACITY)
    else $error("more items in flight than the block can hold");

  // A full block must stall its input.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(pend_r) == CAPACITY && !out_take) |-> in_stall)
    else $error("item accepted while the block is full");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_address) &&
      $stable(out_element_out) && $stable(out_last_element) && $stable(out_size_error)))
    else $error("stalled result changed");

endmodule

bind tensor_transpose_address_generator ttag_checker u_ttag_checker (.*);

// ===== test/transpose_address_checker.sv =====
// ----------------------------------------------------------------------------
// transpose_address_checker: result checker of the transpose address generator
// Watches the configuration, input and result channels. It keeps its own copy
// of the registers and position counters, works out the permuted address of
// every accepted element and compares each accepted result with the oldest
// expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module transpose_address_checker
  import ttag_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ELEM_BITS-1:0]      in_element_in,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ADDR_BITS-1:0]      out_address,
  input  logic [ELEM_BITS-1:0]      out_element_out,
  input  logic                      out_last_element,
  input  logic                      out_size_error,
  output int                        errors,
  output int                        outstanding,
  output int                        results_checked,
  output int                        tensor_ends
);

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
  localparam logic [63:0] ADDR_SPACE = 64'd1 << ADDR_BITS;
  localparam logic [63:0] SIZE_CAP = 64'd1 << DIM_BITS;

  // One expected result item.
  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [ELEM_BITS-1:0] element;
    logic                 last;
    logic                 size_err;
  } transposed_elem_t;

  // Shadow registers and odometer.
  logic [RANK_BITS-1:0]     rank_reg;
  logic [CFG_SIZE_BITS-1:0] size_reg [NUM_DIMS];
  logic [7:0]               perm_reg;
  logic [DIM_BITS-1:0]      position [MAX_RANK];

  transposed_elem_t expected_elements[$];

  // Number of dimensions in use, out-of-range ranks pulled into 1..MAX_RANK.
  function automatic int active_rank();
    int r;
    r = int'(rank_reg);
    if (r < 1) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    return r;
  endfunction

  // Extent of one input dimension, a zero size counting as one, a larger one capped at 2^DIM_BITS.
  function automatic logic [63:0] dim_extent(input int dim);
    logic [63:0] s;
    s = 64'(size_reg[dim]);
    if (s == 64'd0) s = 64'd1;
    if (s > SIZE_CAP) s = SIZE_CAP;
    return s;
  endfunction

  // Address of the current element in the permuted tensor, then one odometer step.
  function automatic transposed_elem_t transpose_element(input logic [ELEM_BITS-1:0] value);
    transposed_elem_t r;
    int used;
    int k;
    int src;
    logic [63:0] addr;
    logic [63:0] volume;
    logic [63:0] extent;
    logic [DIM_BITS-1:0] at;
    bit carry;
    used = active_rank();
    addr = '0;
    volume = 64'd1;
    r.last = 1'b1;
    for (k = used; k < MAX_RANK; k++) position[k] = '0;
    for (k = 0; k < used; k++) begin
      src = int'(perm_reg[2*k +: 2]);
      if (src < used) begin
        extent = dim_extent(src);
        at = position[src];
      end else begin
        // A field naming an unused dimension adds nothing.
        extent = 64'd1;
        at = '0;
      end
      addr = (addr * extent + 64'(at)) & ADDR_MASK;
      volume = volume * dim_extent(k);
      if (64'(position[k]) < dim_extent(k) - 64'd1) r.last = 1'b0;
    end
    r.address = addr[ADDR_BITS-1:0];
    r.element = value;
    r.size_err = (volume > ADDR_SPACE);
    // Innermost dimension first; a counter at or past its last index wraps.
    carry = 1'b1;
    k = used;
    while (carry && k > 0) begin
      k--;
      if (64'(position[k]) >= dim_extent(k) - 64'd1) begin
        position[k] = '0;
      end else begin
        position[k] = position[k] + 1'b1;
        carry = 1'b0;
      end
    end
    return r;
  endfunction

  // Print one line per wrong field and count it.
  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("ERROR @%0t result %0d: %s expected 0x%0h, got 0x%0h",
             $time, results_checked, what, want, got);
    errors++;
  endtask

  // Track register writes, predict accepted elements and check results.
  always @(posedge clk) begin
    transposed_elem_t want;
    if (!rst_n) begin
      rank_reg = RANK_BITS'(MAX_RANK);
      for (int k = 0; k < NUM_DIMS; k++) size_reg[k] = CFG_SIZE_BITS'(1);
      perm_reg = 8'hE4;
      for (int k = 0; k < MAX_RANK; k++) position[k] = '0;
      expected_elements.delete();
      errors = 0;
      outstanding = 0;
      results_checked = 0;
      tensor_ends = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANK:  rank_reg = cfg_data[RANK_BITS-1:0];
          REG_SIZE0: size_reg[0] = cfg_data;
          REG_SIZE1: size_reg[1] = cfg_data;
          REG_SIZE2: size_reg[2] = cfg_data;
          REG_SIZE3: size_reg[3] = cfg_data;
          REG_PERM:  perm_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's element is queued.
      if (out_valid && !out_stall) begin
        if (expected_elements.size() == 0) begin
          $display("ERROR @%0t: result 0x%0h with no element pending",
                   $time, out_address);
          errors++;
        end else begin
          want = expected_elements.pop_front();
          if (out_address !== want.address)
            flag_mismatch("out_address", 64'(want.address), 64'(out_address));
          if (out_element_out !== want.element)
            flag_mismatch("out_element_out", 64'(want.element), 64'(out_element_out));
          if (out_last_element !== want.last)
            flag_mismatch("out_last_element", 64'(want.last), 64'(out_last_element));
          if (out_size_error !== want.size_err)
            flag_mismatch("out_size_error", 64'(want.size_err), 64'(out_size_error));
          if (want.last) tensor_ends++;
          results_checked++;
        end
      end
      if (in_valid && !in_stall) expected_elements.push_back(transpose_element(in_element_in));
      outstanding = expected_elements.size();
    end
  end

endmodule

// ===== test/tb_tensor_transpose_address_generator.sv =====
// ----------------------------------------------------------------------------
// tb_tensor_transpose_address_generator: testbench top
// Drives directed and random tensors through the address generator under a
// series of register settings, with random idling on both channels and long
// result hold-offs. Checking is done by the attached result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tensor_transpose_address_generator;
  import ttag_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 200000;
  // Extra margin after the last expected result has come back.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 200;
  // Indexes the block does not map, used only by noisy phases.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ELEM_BITS-1:0]     in_element_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ADDR_BITS-1:0]     out_address;
  logic [ELEM_BITS-1:0]     out_element_out;
  logic                     out_last_element;
  logic                     out_size_error;

  int mismatches;
  int pending;
  int results_checked;
  int tensor_ends;
  int items_sent = 0;
  int phases = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;

  tensor_transpose_address_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_in    (in_element_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address      (out_address),
    .out_element_out  (out_element_out),
    .out_last_element (out_last_element),
    .out_size_error   (out_size_error)
  );

  transpose_address_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_in    (in_element_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address      (out_address),
    .out_element_out  (out_element_out),
    .out_last_element (out_last_element),
    .out_size_error   (out_size_error),
    .errors           (mismatches),
    .outstanding      (pending),
    .results_checked  (results_checked),
    .tensor_ends      (tensor_ends)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      out_stall <= 1'b1;
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 35);
    end
  end

  // Offer one element, with random idle cycles ahead of it.
  task automatic offer_element(input logic [ELEM_BITS-1:0] value);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic offer_burst(input int count);
    repeat (count) offer_element($urandom());
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain the block, then load all six registers.
  task automatic configure(input logic [CFG_DATA_BITS-1:0] rank,
                           input logic [CFG_DATA_BITS-1:0] s0,
                           input logic [CFG_DATA_BITS-1:0] s1,
                           input logic [CFG_DATA_BITS-1:0] s2,
                           input logic [CFG_DATA_BITS-1:0] s3,
                           input logic [CFG_DATA_BITS-1:0] perm);
    settle();
    write_register(REG_RANK, rank);
    write_register(REG_SIZE0, s0);
    write_register(REG_SIZE1, s1);
    write_register(REG_SIZE2, s2);
    write_register(REG_SIZE3, s3);
    write_register(REG_PERM, perm);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  // One random setting followed by a stream of elements.
  task automatic random_phase();
    int pick;
    int used;
    int volume;
    int count;
    int k;
    int j;
    logic [1:0] order [4];
    logic [1:0] swap;
    logic [CFG_DATA_BITS-1:0] sz [4];
    logic [CFG_DATA_BITS-1:0] rank_word;
    logic [CFG_DATA_BITS-1:0] perm_word;
    pick = $urandom_range(99);
    used = $urandom_range(1, MAX_RANK);
    rank_word = CFG_DATA_BITS'(used);
    for (k = 0; k < 4; k++) order[k] = 2'(k);
    // A proper permutation of the dimensions in use; upper fields are free.
    for (k = used - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      swap = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    for (k = used; k < 4; k++) order[k] = 2'($urandom_range(0, 3));
    perm_word = CFG_DATA_BITS'({order[3], order[2], order[1], order[0]});
    if (pick < 65) begin
      // Small tensors, so that tensor ends come often.
      volume = 1;
      for (k = 0; k < 4; k++) begin
        sz[k] = CFG_DATA_BITS'($urandom_range(1, (used > 2) ? 4 : 9));
        if (k < used) volume = volume * int'(sz[k]);
      end
      count = volume * $urandom_range(1, 2) + $urandom_range(0, 3);
      if (count > 64) count = 64;
    end else if (pick < 80) begin
      // Some large dimensions: high address bits and size errors.
      for (k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: sz[k] = CFG_DATA_BITS'(4096);
          1: sz[k] = CFG_DATA_BITS'($urandom_range(1, 4096));
          default: sz[k] = CFG_DATA_BITS'($urandom_range(1, 16));
        endcase
      end
      count = $urandom_range(16, 48);
    end else begin
      // Raw register values of any kind.
      rank_word = CFG_DATA_BITS'($urandom_range(0, 8191));
      perm_word = CFG_DATA_BITS'($urandom_range(0, 8191));
      for (k = 0; k < 4; k++) sz[k] = CFG_DATA_BITS'($urandom_range(0, 8191));
      count = $urandom_range(8, 32);
    end
    configure(rank_word, sz[0], sz[1], sz[2], sz[3], perm_word);
    if (pick >= 80) begin
      write_register(REG_SPARE_A, CFG_DATA_BITS'($urandom()));
      write_register(REG_SPARE_B, CFG_DATA_BITS'($urandom()));
      cfg_valid <= 1'b0;
    end
    // A quiet stretch with no idling on either side.
    idle_on <= !(phases >= 12 && phases < 20);
    // Two long result hold-offs while elements keep coming.
    if (phases == 10 || phases == 24) begin
      hold_requests <= hold_requests + 1;
      if (count < 40) count = 40;
    end
    offer_burst(count);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: rank 4, unit sizes, every element is a whole tensor.
    offer_element(32'h0000_0000);
    offer_element(32'hFFFF_FFFF);
    offer_element(32'hA5A5_5A5A);
    // Rank 0 acts as rank 1.
    configure(0, 3, 1, 1, 1, 13'h0E4);
    offer_burst(3);
    // Rank above the maximum, largest sizes, reversed order, size error.
    configure(7, 4096, 4096, 1, 2, 13'h01B);
    offer_burst(3);
    // Oversized size clamps; product exactly fills the address space.
    configure(4, 8191, 4096, 1, 1, 13'h0E4);
    offer_burst(2);
    // Zero size, and an order that names dimensions beyond the rank.
    configure(2, 0, 3, 1, 1, 13'h0E7);
    offer_burst(3);
    // Shrink a dimension mid-tensor so its counter lies past the last index.
    configure(2, 1, 5, 1, 1, 13'h0E4);
    offer_burst(3);
    configure(2, 1, 2, 1, 1, 13'h0E4);
    offer_burst(2);
    // Drop the rank mid-tensor: unused counters are held at zero.
    configure(1, 2, 1, 1, 1, 13'h0E4);
    offer_burst(2);
    // The same dimension named at every output position.
    configure(3, 2, 3, 4, 1, 13'h0AA);
    offer_burst(3);

    while (items_sent < ITEM_TARGET + 24) random_phase();
    settle();

    $display("Run covered %0d elements over %0d register settings,", items_sent, phases);
    $display("with %0d results checked and %0d tensor ends.", results_checked, tensor_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
